// File: hw/rtl/vnst_pkg.sv
// ----------------------------------------------------------------------------
// vnst_pkg
// shared types, widths and command / status codes of the visible nearest
// source table
// ----------------------------------------------------------------------------
package vnst_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ID_W        = 16;
    localparam int DIST_W      = 24;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SORT   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   source_id;
        logic              has_sight;
        logic [DIST_W-1:0] distance;
    } t_cmd_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     entry_id;
        logic                entry_sight;
        logic [DIST_W-1:0]   entry_distance;
        logic                entry_valid;
        logic [CNT_W-1:0]    fill_count;
        logic                last;
    } t_result_item;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              sight;
        logic [DIST_W-1:0] distance;
    } t_entry;

endpackage

// File: hw/rtl/visible_nearest_source_table.sv
// ----------------------------------------------------------------------------
// visible_nearest_source_table
// ordered table of sources with add, remove, update and a sort-and-emit pass
// ----------------------------------------------------------------------------
// A command item is taken when start is high and busy is low; busy then stays
// high until the item's last result has been put out. Every result appears on
// o_result for exactly one cycle with o_strobe high and cannot be held off, so
// the receiver must take it in that cycle. All work goes through one table
// read port, one write port and one id / distance comparator under a small
// sequencer, so the time per item is set by how many table entries that port
// has to visit. Add and update search the table from slot 0 up to the id, or
// to the end when it is absent; remove searches likewise and then shifts the
// later entries down; sort runs a selection sort (one compare per cycle, a
// swap as two writes, slot i then slot m) followed by one result per cycle
// for each entry. Sort of an empty table gives a single result with
// entry_valid low. Ids are compared over the whole 16 bits; the distance
// field is as wide as the stored distance, so it needs no saturation.
// ----------------------------------------------------------------------------
module visible_nearest_source_table (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  vnst_pkg::t_cmd_item    i_cmd,
    output logic                   o_strobe,
    output vnst_pkg::t_result_item o_result
);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;  // linear id lookup
    localparam logic [2:0] ST_SHIFT  = 3'd2;  // remove: move later entries down
    localparam logic [2:0] ST_LOAD   = 3'd3;  // sort: fetch entry i
    localparam logic [2:0] ST_CMP    = 3'd4;  // sort: compare entry j with best
    localparam logic [2:0] ST_SWAP_I = 3'd5;  // sort: write best into slot i
    localparam logic [2:0] ST_SWAP_M = 3'd6;  // sort: write old slot i into slot m
    localparam logic [2:0] ST_EMIT   = 3'd7;  // one result per entry

    // control registers
    logic [2:0]                  r_state, n_state;
    logic [vnst_pkg::CNT_W-1:0]  r_count, n_count;
    logic [vnst_pkg::CNT_W-1:0]  r_ptr,   n_ptr;
    logic                        r_strobe, n_strobe;

    // payload registers
    vnst_pkg::t_cmd_item         r_req,  n_req;
    logic [vnst_pkg::IDX_W-1:0]  r_i,    n_i;
    logic [vnst_pkg::IDX_W-1:0]  r_m,    n_m;
    vnst_pkg::t_entry            r_cur,  n_cur;
    vnst_pkg::t_entry            r_best, n_best;
    vnst_pkg::t_result_item      r_out,  n_out;

    // table storage, one read and one write address per cycle
    vnst_pkg::t_entry            r_tab [vnst_pkg::MAX_ENTRIES];
    logic [vnst_pkg::IDX_W-1:0]  rd_idx;
    vnst_pkg::t_entry            rd_data;
    logic                        w_en;
    logic [vnst_pkg::IDX_W-1:0]  w_idx;
    vnst_pkg::t_entry            w_data;

    // shared compare unit
    logic                        id_hit;
    logic                        better;

    // the load step reads slot i, every other step reads at the pointer
    assign rd_idx  = (r_state == ST_LOAD) ? r_i : r_ptr[vnst_pkg::IDX_W-1:0];
    assign rd_data = r_tab[rd_idx];

    assign id_hit = (rd_data.id == r_req.source_id);
    // sighted entries first, then strictly smaller distance among sighted
    assign better = rd_data.sight &&
                    (!r_best.sight || (rd_data.distance < r_best.distance));

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_strobe = 1'b0;
        n_req    = r_req;
        n_i      = r_i;
        n_m      = r_m;
        n_cur    = r_cur;
        n_best   = r_best;
        n_out    = '0;
        w_en     = 1'b0;
        w_idx    = r_ptr[vnst_pkg::IDX_W-1:0];
        w_data   = rd_data;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req = i_cmd;
                    n_ptr = '0;
                    n_i   = '0;
                    if (i_cmd.cmd == vnst_pkg::CMD_SORT) begin
                        // fewer than two entries are already in order
                        n_state = (r_count < vnst_pkg::CNT_W'(2)) ? ST_EMIT : ST_LOAD;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH: begin
                n_out.last = 1'b1;
                if (r_ptr == r_count) begin
                    // id not in the table
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                    if (r_req.cmd == vnst_pkg::CMD_ADD) begin
                        if (r_count == vnst_pkg::CNT_W'(vnst_pkg::MAX_ENTRIES)) begin
                            n_out.status = vnst_pkg::STS_FULL;
                        end else begin
                            w_en            = 1'b1;
                            w_idx           = r_count[vnst_pkg::IDX_W-1:0];
                            w_data.id       = r_req.source_id;
                            w_data.sight    = 1'b0;
                            w_data.distance = '0;
                            n_count         = r_count + vnst_pkg::CNT_W'(1);
                            n_out.status    = vnst_pkg::STS_OK;
                        end
                    end else begin
                        n_out.status = vnst_pkg::STS_NOT_FOUND;
                    end
                end else if (id_hit) begin
                    unique case (r_req.cmd)
                        vnst_pkg::CMD_ADD: begin
                            n_strobe     = 1'b1;
                            n_state      = ST_IDLE;
                            n_out.status = vnst_pkg::STS_DUPLICATE;
                        end
                        vnst_pkg::CMD_UPDATE: begin
                            w_en            = 1'b1;
                            w_data.sight    = r_req.has_sight;
                            w_data.distance = r_req.distance;
                            n_strobe        = 1'b1;
                            n_state         = ST_IDLE;
                            n_out.status    = vnst_pkg::STS_OK;
                        end
                        vnst_pkg::CMD_REMOVE: begin
                            n_ptr   = r_ptr + vnst_pkg::CNT_W'(1);
                            n_state = ST_SHIFT;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end else begin
                    n_ptr = r_ptr + vnst_pkg::CNT_W'(1);
                end
                n_out.fill_count = n_count;
            end

            ST_SHIFT: begin
                if (r_ptr < r_count) begin
                    // move the entry at the pointer one slot down
                    w_en  = 1'b1;
                    w_idx = vnst_pkg::IDX_W'(r_ptr - vnst_pkg::CNT_W'(1));
                    n_ptr = r_ptr + vnst_pkg::CNT_W'(1);
                end else begin
                    n_count          = r_count - vnst_pkg::CNT_W'(1);
                    n_strobe         = 1'b1;
                    n_state          = ST_IDLE;
                    n_out.status     = vnst_pkg::STS_OK;
                    n_out.fill_count = n_count;
                    n_out.last       = 1'b1;
                end
            end

            ST_LOAD: begin
                n_cur   = rd_data;
                n_best  = rd_data;
                n_m     = r_i;
                n_ptr   = vnst_pkg::CNT_W'(r_i) + vnst_pkg::CNT_W'(1);
                n_state = ST_CMP;
            end

            ST_CMP: begin
                if (better) begin
                    n_best = rd_data;
                    n_m    = r_ptr[vnst_pkg::IDX_W-1:0];
                end
                if ((r_ptr + vnst_pkg::CNT_W'(1)) == r_count) begin
                    n_state = ST_SWAP_I;
                end else begin
                    n_ptr = r_ptr + vnst_pkg::CNT_W'(1);
                end
            end

            ST_SWAP_I: begin
                w_en    = 1'b1;
                w_idx   = r_i;
                w_data  = r_best;
                n_state = ST_SWAP_M;
            end

            ST_SWAP_M: begin
                // when m equals i this rewrites the same entry
                w_en   = 1'b1;
                w_idx  = r_m;
                w_data = r_cur;
                if ((vnst_pkg::CNT_W'(r_i) + vnst_pkg::CNT_W'(2)) < r_count) begin
                    n_i     = r_i + vnst_pkg::IDX_W'(1);
                    n_state = ST_LOAD;
                end else begin
                    n_ptr   = '0;
                    n_state = ST_EMIT;
                end
            end

            ST_EMIT: begin
                n_strobe         = 1'b1;
                n_out.status     = vnst_pkg::STS_OK;
                n_out.fill_count = r_count;
                if (r_count == '0) begin
                    n_out.last = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    n_out.entry_id       = rd_data.id;
                    n_out.entry_sight    = rd_data.sight;
                    n_out.entry_distance = rd_data.distance;
                    n_out.entry_valid    = 1'b1;
                    if ((r_ptr + vnst_pkg::CNT_W'(1)) == r_count) begin
                        n_out.last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_ptr = r_ptr + vnst_pkg::CNT_W'(1);
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ptr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ptr    <= n_ptr;
            r_strobe <= n_strobe;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_i    <= n_i;
        r_m    <= n_m;
        r_cur  <= n_cur;
        r_best <= n_best;
        r_out  <= n_out;
    end

    // table write port
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tab[w_idx] <= w_data;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

// File: hw/rtl/vnst_checker.sv
// ----------------------------------------------------------------------------
// vnst_checker
// port-level checks on the visible nearest source table
// ----------------------------------------------------------------------------
module vnst_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input vnst_pkg::t_cmd_item    i_cmd,
    input logic                   o_strobe,
    input vnst_pkg::t_result_item o_result
);

    // an accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepting an item");

    // entries of a sort come in consecutive cycles until the last
    a_emit_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |=> o_strobe)
        else $error("gap inside a burst of results");

    // the last result frees the block, earlier ones do not
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.last == !busy))
        else $error("busy does not match last result");

    // a result without an entry is a single final result with cleared fields
    a_no_entry_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.entry_valid |->
            o_result.last && (o_result.entry_id == '0) && (o_result.entry_distance == '0))
        else $error("status result carries entry data");

    // fill count never exceeds the table size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.fill_count <= vnst_pkg::CNT_W'(vnst_pkg::MAX_ENTRIES)))
        else $error("fill count beyond table size");

endmodule

bind visible_nearest_source_table vnst_checker u_vnst_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// File: tb/sv/vnst_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// vnst_scoreboard_pkg
// tracks the source table as the block should hold it and checks every
// result item against the expected ones in order
// ----------------------------------------------------------------------------
package vnst_scoreboard_pkg;

    import vnst_pkg::*;

    class source_table_scoreboard;

        t_entry         slots[MAX_ENTRIES];
        int unsigned    fill;
        t_result_item   expected_results[$];
        int unsigned    error_count;
        int unsigned    cmd_seen[4];
        int unsigned    full_sorts;
        int unsigned    results_checked;

        function new();
            fill            = 0;
            error_count     = 0;
            full_sorts      = 0;
            results_checked = 0;
            foreach (cmd_seen[k]) cmd_seen[k] = 0;
        endfunction

        function int find_slot(logic [ID_W-1:0] id);
            for (int k = 0; k < fill; k++)
                if (slots[k].id == id) return k;
            return -1;
        endfunction

        // idx < 0 means a status-only result
        function void push_result(logic [STATUS_W-1:0] status, int idx, bit last);
            t_result_item r;
            r = '0;
            r.status = status;
            if (idx >= 0) begin
                r.entry_id       = slots[idx].id;
                r.entry_sight    = slots[idx].sight;
                r.entry_distance = slots[idx].distance;
                r.entry_valid    = 1'b1;
            end
            r.fill_count = CNT_W'(fill);
            r.last       = last;
            expected_results.push_back(r);
        endfunction

        // selection sort: sighted entries first, nearest first, strict compare
        function void sort_slots();
            int     m;
            t_entry tmp;
            for (int i = 0; i + 1 < fill; i++) begin
                m = i;
                for (int j = i + 1; j < fill; j++) begin
                    if (slots[j].sight && slots[m].sight) begin
                        if (slots[j].distance < slots[m].distance) m = j;
                    end else if (slots[j].sight) begin
                        m = j;
                    end
                end
                tmp      = slots[i];
                slots[i] = slots[m];
                slots[m] = tmp;
            end
        endfunction

        // called for every item the block takes
        function void note_command(t_cmd_item c);
            int idx;
            idx = find_slot(c.source_id);
            cmd_seen[c.cmd]++;
            case (c.cmd)
                CMD_ADD: begin
                    if (idx >= 0) begin
                        push_result(STS_DUPLICATE, -1, 1'b1);
                    end else if (fill >= MAX_ENTRIES) begin
                        push_result(STS_FULL, -1, 1'b1);
                    end else begin
                        slots[fill] = '{id: c.source_id, sight: 1'b0, distance: '0};
                        fill++;
                        push_result(STS_OK, -1, 1'b1);
                    end
                end
                CMD_REMOVE: begin
                    if (idx < 0) begin
                        push_result(STS_NOT_FOUND, -1, 1'b1);
                    end else begin
                        for (int k = idx; k + 1 < fill; k++) slots[k] = slots[k+1];
                        fill--;
                        push_result(STS_OK, -1, 1'b1);
                    end
                end
                CMD_UPDATE: begin
                    if (idx < 0) begin
                        push_result(STS_NOT_FOUND, -1, 1'b1);
                    end else begin
                        slots[idx].sight    = c.has_sight;
                        slots[idx].distance = c.distance;
                        push_result(STS_OK, -1, 1'b1);
                    end
                end
                default: begin
                    if (fill == MAX_ENTRIES) full_sorts++;
                    sort_slots();
                    if (fill == 0) begin
                        push_result(STS_OK, -1, 1'b1);
                    end else begin
                        for (int k = 0; k < fill; k++)
                            push_result(STS_OK, k, (k + 1) == fill);
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, longint unsigned exp_v,
                                    longint unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
                error_count++;
            end
        endfunction

        function void check_result(t_result_item r);
            t_result_item e;
            if (expected_results.size() == 0) begin
                $error("unexpected result item: %h", r);
                error_count++;
                return;
            end
            e = expected_results.pop_front();
            results_checked++;
            compare_field("status",         e.status,         r.status);
            compare_field("entry_id",       e.entry_id,       r.entry_id);
            compare_field("entry_sight",    e.entry_sight,    r.entry_sight);
            compare_field("entry_distance", e.entry_distance, r.entry_distance);
            compare_field("entry_valid",    e.entry_valid,    r.entry_valid);
            compare_field("fill_count",     e.fill_count,     r.fill_count);
            compare_field("last",           e.last,           r.last);
        endfunction

    endclass

endpackage

// File: tb/sv/tb_visible_nearest_source_table.sv
// ----------------------------------------------------------------------------
// tb_visible_nearest_source_table
// self-checking bench for the visible nearest source table: a directed
// opening walks the table through empty, full and every status code, then
// random command streams with random sender gaps fill, churn and sort it,
// each result item checked against a predicted copy of the table
// ----------------------------------------------------------------------------
module tb_visible_nearest_source_table;

    timeunit 1ns;
    timeprecision 1ps;

    import vnst_pkg::*;
    import vnst_scoreboard_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int POOL_SIZE    = 24;
    // a full-table sort runs its whole selection sort before its first result item
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 40;

    logic         i_clk;
    logic         i_rst_n;
    logic         start;
    logic         busy;
    t_cmd_item    i_cmd;
    logic         o_strobe;
    t_result_item o_result;

    source_table_scoreboard sb;
    logic [ID_W-1:0]        id_pool[POOL_SIZE];
    int unsigned            quiet_cycles;

    visible_nearest_source_table u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // result monitor and stall watchdog, sampling the values from before the edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (o_strobe) sb.check_result(o_result);
            if (o_strobe || (start && !busy)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("visible_nearest_source_table test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // hold the item on the port until the block takes it; start stays high
    // afterwards so back-to-back items need no extra edge
    task automatic send_command(input t_cmd_item c);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(c);
    endtask

    task automatic send_fields(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                               input logic sight, input logic [DIST_W-1:0] dist_v);
        t_cmd_item c;
        c = '{cmd: cmd, source_id: id, has_sight: sight, distance: dist_v};
        send_command(c);
    endtask

    task automatic idle_gap(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // sender stops until every predicted result item has come back
    task automatic drain_results();
        start <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
    endtask

    // mostly well-formed traffic on a small id pool so hits are common;
    // a tenth of ids are fully random, which almost always miss
    function automatic t_cmd_item random_command(input bit grow);
        t_cmd_item   c;
        int unsigned r;
        int unsigned add_w;
        int unsigned rem_w;
        c.distance  = DIST_W'($urandom());
        c.has_sight = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 30)      c.distance = DIST_W'($urandom_range(0, 3));
        else if (r < 45) c.distance = '1;
        add_w = grow ? 50 : 22;
        rem_w = grow ? 13 : 40;
        r = $urandom_range(0, 99);
        if (r < 12)                  c.cmd = CMD_SORT;
        else if (r < 12 + add_w)     c.cmd = CMD_ADD;
        else if (r < 12 + add_w + rem_w) c.cmd = CMD_REMOVE;
        else                         c.cmd = CMD_UPDATE;
        if ($urandom_range(0, 9) == 0) begin
            c.source_id = ID_W'($urandom());
        end else if ((c.cmd == CMD_REMOVE || c.cmd == CMD_UPDATE) && sb.fill > 0
                     && $urandom_range(0, 9) < 7) begin
            c.source_id = sb.slots[$urandom_range(0, sb.fill - 1)].id;
        end else begin
            c.source_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return c;
    endfunction

    initial begin
        bit grow;
        sb      = new();
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        foreach (id_pool[k]) id_pool[k] = ID_W'($urandom());
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed opening ----
        // sort of an empty table gives a single empty item
        send_fields(CMD_SORT,   16'h1234, 1'b0, '0);
        // remove and update of an absent id
        send_fields(CMD_REMOVE, 16'h1234, 1'b0, '0);
        send_fields(CMD_UPDATE, 16'h1234, 1'b1, '1);
        // id extremes, then a duplicate add
        send_fields(CMD_ADD,    16'h0000, 1'b0, '0);
        send_fields(CMD_ADD,    16'hFFFF, 1'b0, '0);
        send_fields(CMD_ADD,    16'h0000, 1'b1, '1);
        // walking-one ids fill the table up to its limit
        for (int k = 0; k < MAX_ENTRIES - 2; k++)
            send_fields(CMD_ADD, ID_W'(1) << k, 1'b0, '0);
        // new id on a full table, then a present id on a full table
        // (duplicate wins over full)
        send_fields(CMD_ADD,    16'h8001, 1'b0, '0);
        send_fields(CMD_ADD,    16'hFFFF, 1'b0, '0);
        // max distance with sight, a tie at max, zero distance, and a distance
        // kept without sight
        send_fields(CMD_UPDATE, 16'hFFFF, 1'b1, '1);
        send_fields(CMD_UPDATE, 16'h0020, 1'b1, '1);
        send_fields(CMD_UPDATE, 16'h0008, 1'b1, '0);
        send_fields(CMD_UPDATE, 16'h0000, 1'b0, 24'd5);
        send_fields(CMD_SORT,   16'h0000, 1'b0, '0);
        // remove from the middle shifts later entries down
        send_fields(CMD_REMOVE, 16'h0080, 1'b0, '0);
        drain_results();

        // ---- random part ----
        grow = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // alternate filling and draining phases so the table swings
            // between empty and full
            if (n % 60 == 0) grow = ~grow | (n == 0);
            send_command(random_command(grow));
            if (n == 300) begin
                drain_results();
            end else if ((n < 150 || n >= 260) && $urandom_range(0, 99) < 33) begin
                // gaps only outside items 150 to 259, which run back to back under full load
                idle_gap($urandom_range(1, 6));
            end
        end

        // ---- wind-down ----
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("ran %0d add, %0d remove, %0d update and %0d sort items (%0d on a full table)",
                 sb.cmd_seen[CMD_ADD], sb.cmd_seen[CMD_REMOVE],
                 sb.cmd_seen[CMD_UPDATE], sb.cmd_seen[CMD_SORT], sb.full_sorts);
        $display("checked %0d result items, %0d mismatches",
                 sb.results_checked, sb.error_count);
        if (sb.error_count == 0) begin
            $display("visible_nearest_source_table test passed");
        end else begin
            $display("visible_nearest_source_table test failed");
        end
        $finish;
    end

endmodule
